FILE: sv/zmodem_frame_encoder_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the ZMODEM frame encoder
// Immediate-implication and next-cycle checks, empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef ZMODEM_FRAME_ENCODER_TOP_MACROS_SVH
`define ZMODEM_FRAME_ENCODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle check: when ante holds, cons holds.
`define ZFE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle check: when ante holds, cons holds in the next cycle.
`define ZFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ZFE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ZFE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/zfe_pkg.sv
// ---------------------------------------------------------------------------
// ZMODEM frame encoder package
// Word types, line constants and the CRC and hex helper functions.
// ---------------------------------------------------------------------------
package zfe_pkg;

  // Command codes of an input word
  typedef enum logic [1:0] {
    CMD_DATA = 2'd0,
    CMD_END  = 2'd1,
    CMD_HEX  = 2'd2,
    CMD_BIN  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  in_byte;
    logic [31:0] header_arg;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  localparam logic [7:0]  ESC_BYTE   = 8'h18;
  localparam logic [7:0]  PAD_BYTE   = 8'h2A;
  localparam logic [7:0]  ESC_XOR    = 8'h40;
  localparam logic [7:0]  ESC_MAX    = 8'h1F;
  localparam logic [7:0]  HEX_TAG    = 8'h42;
  localparam logic [7:0]  BIN_TAG    = 8'h43;
  localparam logic [7:0]  CR_BYTE    = 8'h0D;
  localparam logic [7:0]  LF_BYTE    = 8'h0A;
  localparam logic [31:0] CRC32_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC32_INIT = 32'hFFFFFFFF;
  localparam logic [15:0] CRC16_POLY = 16'h1021;

  // One byte of the reflected CRC-32, bit by bit
  function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC32_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // One byte of the MSB-first CRC-16
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ((r << 1) ^ CRC16_POLY) : (r << 1);
    end
    return r;
  endfunction

  // Upper-case ASCII hex digit
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    return (v < 4'd10) ? ({4'h0, v} + 8'h30) : ({4'h0, v} + 8'h37);
  endfunction

  // Bytes in the control range and the pad byte go out escaped
  function automatic logic needs_escape(input logic [7:0] b);
    return (b <= ESC_MAX) || (b == PAD_BYTE);
  endfunction

  // Byte of a 32-bit word, index 0 is the most significant
  function automatic logic [7:0] byte_of32(input logic [31:0] w, input logic [1:0] idx);
    return w[(5'd24 - {idx, 3'b000}) +: 8];
  endfunction

endpackage

FILE: sv/zmodem_frame_encoder_top.sv
// ---------------------------------------------------------------------------
// ZMODEM frame encoder
// Turns data, end and header commands into an escaped serial byte stream.
// ---------------------------------------------------------------------------
// An accepted item is registered in item_r; its line words go out through out_data_r.
// Throughput: one line word per cycle from the output register while out_ready holds;
//   a data byte is 1 or 2 words, an end 6 to 10, a hex header 19, a binary 12 to 21.
// The next item is taken in the cycle the current item's final word is emitted.
// Reset (synchronous, active low): running CRC-32 to all ones, crc16_init to 0.
`include "zmodem_frame_encoder_top_macros.svh"

module zmodem_frame_encoder_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  zfe_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output zfe_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);

  zfe_pkg::in_item_t  item_r;
  zfe_pkg::out_item_t out_data_r, out_data_nxt;
  logic               busy_r, busy_nxt;
  logic [4:0]         pos_r, pos_nxt;
  logic               phase_r, phase_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        sub_crc_r, sub_crc_nxt;
  logic [31:0]        wcrc_r, wcrc_nxt;
  logic [15:0]        h16_r, h16_nxt;
  logic [15:0]        crc16_init_r;

  logic               step, in_fire;
  logic [7:0]         sym_val;
  logic               sym_esc, sym_last, sym_needs_esc, sym_done;
  logic [2:0]         pay_idx;
  logic [7:0]         pay_val;
  logic [31:0]        crc_base, crc_res;
  logic [7:0]         crc_in;
  logic [31:0]        crc_out;

  // Emit one line word whenever busy and the output register is free
  assign step     = busy_r && (!out_valid_r || out_ready);
  assign in_ready = !busy_r || (step && sym_done && sym_last);
  assign in_fire  = in_valid && in_ready;

  assign crc_out = ~wcrc_r;

  // Select the payload byte: type, then argument bytes first-to-last
  always_comb begin
    case (pay_idx)
      3'd0:    pay_val = item_r.in_byte;
      3'd1:    pay_val = item_r.header_arg[31:24];
      3'd2:    pay_val = item_r.header_arg[23:16];
      3'd3:    pay_val = item_r.header_arg[15:8];
      default: pay_val = item_r.header_arg[7:0];
    endcase
  end

  // Decode the current symbol of the item's frame
  always_comb begin
    sym_val  = 8'h00;
    sym_esc  = 1'b0;
    sym_last = 1'b0;
    pay_idx  = 3'd0;
    case (item_r.cmd)
      zfe_pkg::CMD_DATA: begin
        sym_val  = item_r.in_byte;
        sym_esc  = 1'b1;
        sym_last = 1'b1;
      end
      zfe_pkg::CMD_END: begin
        case (pos_r) inside
          5'd0:          sym_val = zfe_pkg::ESC_BYTE;
          5'd1:          sym_val = item_r.in_byte;
          [5'd2:5'd5]: begin
            sym_val  = zfe_pkg::byte_of32(crc_out, 2'(pos_r - 5'd2));
            sym_esc  = 1'b1;
            sym_last = (pos_r == 5'd5);
          end
          default:       sym_val = 8'h00;
        endcase
      end
      zfe_pkg::CMD_HEX: begin
        pay_idx = 3'((pos_r - 5'd3) >> 1);
        case (pos_r) inside
          5'd0:          sym_val = zfe_pkg::PAD_BYTE;
          5'd1:          sym_val = zfe_pkg::ESC_BYTE;
          5'd2:          sym_val = zfe_pkg::HEX_TAG;
          [5'd3:5'd12]:  sym_val = zfe_pkg::hex_digit(pos_r[0] ? pay_val[7:4] : pay_val[3:0]);
          [5'd13:5'd14]: sym_val = zfe_pkg::hex_digit(pos_r[0] ? h16_r[15:12] : h16_r[11:8]);
          [5'd15:5'd16]: sym_val = zfe_pkg::hex_digit(pos_r[0] ? h16_r[7:4] : h16_r[3:0]);
          5'd17:         sym_val = zfe_pkg::CR_BYTE;
          5'd18: begin
            sym_val  = zfe_pkg::LF_BYTE;
            sym_last = 1'b1;
          end
          default:       sym_val = 8'h00;
        endcase
      end
      zfe_pkg::CMD_BIN: begin
        pay_idx = 3'(pos_r - 5'd3);
        case (pos_r) inside
          5'd0:          sym_val = zfe_pkg::PAD_BYTE;
          5'd1:          sym_val = zfe_pkg::ESC_BYTE;
          5'd2:          sym_val = zfe_pkg::BIN_TAG;
          [5'd3:5'd7]: begin
            sym_val = pay_val;
            sym_esc = 1'b1;
          end
          [5'd8:5'd11]: begin
            sym_val  = zfe_pkg::byte_of32(crc_out, 2'(pos_r - 5'd8));
            sym_esc  = 1'b1;
            sym_last = (pos_r == 5'd11);
          end
          default:       sym_val = 8'h00;
        endcase
      end
      default: sym_val = 8'h00;
    endcase
  end

  assign sym_needs_esc = sym_esc && zfe_pkg::needs_escape(sym_val);
  assign sym_done      = !sym_needs_esc || phase_r;

  // Shared CRC-32 byte update: running subpacket CRC or binary header CRC
  assign crc_base = (item_r.cmd == zfe_pkg::CMD_BIN)
                  ? ((pos_r == 5'd3) ? zfe_pkg::CRC32_INIT : wcrc_r) : sub_crc_r;
  assign crc_in   = (item_r.cmd == zfe_pkg::CMD_BIN) ? pay_val : item_r.in_byte;
  assign crc_res  = zfe_pkg::crc32_byte(crc_base, crc_in);

  // Advance the frame sequencer and update CRCs on a symbol's first word
  always_comb begin
    busy_nxt      = busy_r;
    pos_nxt       = pos_r;
    phase_nxt     = phase_r;
    sub_crc_nxt   = sub_crc_r;
    wcrc_nxt      = wcrc_r;
    h16_nxt       = h16_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (step) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.last     = sym_done && sym_last;
      if (sym_needs_esc && !phase_r) begin
        out_data_nxt.out_byte = zfe_pkg::ESC_BYTE;
      end else if (sym_needs_esc) begin
        out_data_nxt.out_byte = sym_val ^ zfe_pkg::ESC_XOR;
      end else begin
        out_data_nxt.out_byte = sym_val;
      end
      if (!phase_r) begin
        case (item_r.cmd)
          zfe_pkg::CMD_DATA: sub_crc_nxt = crc_res;
          zfe_pkg::CMD_END: begin
            if (pos_r == 5'd1) begin
              wcrc_nxt    = crc_res;
              sub_crc_nxt = zfe_pkg::CRC32_INIT;
            end
          end
          zfe_pkg::CMD_HEX: begin
            if (pos_r[0] && (pos_r >= 5'd3) && (pos_r <= 5'd11)) begin
              h16_nxt = zfe_pkg::crc16_byte((pos_r == 5'd3) ? crc16_init_r : h16_r,
                                            pay_val);
            end
          end
          zfe_pkg::CMD_BIN: begin
            if ((pos_r >= 5'd3) && (pos_r <= 5'd7)) begin
              wcrc_nxt = crc_res;
            end
          end
          default: sub_crc_nxt = sub_crc_r;
        endcase
      end
      if (sym_done) begin
        phase_nxt = 1'b0;
        pos_nxt   = pos_r + 5'd1;
        if (sym_last) begin
          busy_nxt = 1'b0;
        end
      end else begin
        phase_nxt = 1'b1;
      end
    end
    if (in_fire) begin
      busy_nxt  = 1'b1;
      pos_nxt   = 5'd0;
      phase_nxt = 1'b0;
    end
  end

  // Control state, running CRC and CRC-16 seed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      pos_r        <= 5'd0;
      phase_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      sub_crc_r    <= zfe_pkg::CRC32_INIT;
      crc16_init_r <= 16'h0000;
    end else begin
      busy_r      <= busy_nxt;
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      sub_crc_r   <= sub_crc_nxt;
      if (cfg_wr_en) begin
        crc16_init_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
    end
    wcrc_r     <= wcrc_nxt;
    h16_r      <= h16_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Second phase only exists for an escaped symbol
  `ZFE_ASSERT_NOW(a_phase_escaped, clk, rst_n, busy_r && phase_r, sym_needs_esc)
  // Sequencer never runs past the longest frame
  `ZFE_ASSERT_NOW(a_pos_bound, clk, rst_n, busy_r, pos_r <= 5'd18)
  // Escape prefix word is never flagged as final
  `ZFE_ASSERT_NEXT(a_esc_prefix, clk, rst_n, step && !sym_done,
                   (out_data_r.out_byte == zfe_pkg::ESC_BYTE) && !out_data_r.last)
  // Final word with no new item leaves the sequencer idle
  `ZFE_ASSERT_NEXT(a_idle_after_last, clk, rst_n, step && sym_done && sym_last && !in_fire,
                   !busy_r && out_valid_r && out_data_r.last)

endmodule

FILE: tb/tb_top.sv
// ---------------------------------------------------------------------------
// Testbench for the ZMODEM frame encoder
// Drives data, end, hex header and binary header words through the
// encoder and predicts every line word: escaping, the running subpacket
// CRC-32, the header CRC-16 under several seed settings, and the last flag.
// Both handshakes idle at random, and the receiver stalls once for a long
// stretch so that the encoder backs up into its input.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 30;
  localparam int PHASE_WORDS = 90;

  // Predicts the line stream of the encoder and checks the words it emits
  class frame_scoreboard;
    zfe_pkg::out_item_t line_q[$];
    logic [31:0]        run_crc;
    logic [15:0]        hdr_seed;
    int                 mismatches;
    int                 checked;
    int                 n_data;
    int                 n_end;
    int                 n_hex;
    int                 n_bin;

    function new();
      run_crc  = zfe_pkg::CRC32_INIT;
      hdr_seed = 16'h0000;
    endfunction

    function void set_seed(logic [15:0] v);
      hdr_seed = v;
    endfunction

    function int pending();
      return line_q.size();
    endfunction

    // Reflected CRC-32, one bit at a time, LSB first
    function logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      logic        fb;
      int          k;
      r = c;
      for (k = 0; k < 8; k++) begin
        fb = r[0] ^ b[k];
        r  = r >> 1;
        if (fb) r = r ^ zfe_pkg::CRC32_POLY;
      end
      return r;
    endfunction

    // MSB-first CRC-16, one bit at a time
    function logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      int          k;
      r = c;
      for (k = 7; k >= 0; k--) begin
        fb = r[15] ^ b[k];
        r  = r << 1;
        if (fb) r = r ^ zfe_pkg::CRC16_POLY;
      end
      return r;
    endfunction

    function logic [7:0] hex_char(logic [3:0] nib);
      if (nib < 4'd10) return 8'h30 + {4'h0, nib};
      return 8'h41 + {4'h0, nib} - 8'd10;
    endfunction

    function void put_raw(logic [7:0] b);
      zfe_pkg::out_item_t w;
      w.out_byte = b;
      w.last     = 1'b0;
      line_q.push_back(w);
    endfunction

    function void put_esc(logic [7:0] b);
      if (b <= zfe_pkg::ESC_MAX || b == zfe_pkg::PAD_BYTE) begin
        put_raw(zfe_pkg::ESC_BYTE);
        put_raw(b ^ zfe_pkg::ESC_XOR);
      end else begin
        put_raw(b);
      end
    endfunction

    function void put_hex(logic [7:0] b);
      put_raw(hex_char(b[7:4]));
      put_raw(hex_char(b[3:0]));
    endfunction

    // Append the line words that one accepted input word causes
    function void note_input(zfe_pkg::in_item_t w);
      logic [7:0]         field [5];
      logic [31:0]        c;
      logic [15:0]        h;
      zfe_pkg::out_item_t tail;
      int                 i;
      field[0] = w.in_byte;
      for (i = 0; i < 4; i++) field[i + 1] = w.header_arg[31 - 8 * i -: 8];
      case (w.cmd)
        zfe_pkg::CMD_DATA: begin
          run_crc = crc32_step(run_crc, w.in_byte);
          put_esc(w.in_byte);
          n_data++;
        end
        zfe_pkg::CMD_END: begin
          c = ~crc32_step(run_crc, w.in_byte);
          put_raw(zfe_pkg::ESC_BYTE);
          put_raw(w.in_byte);
          for (i = 0; i < 4; i++) put_esc(c[31 - 8 * i -: 8]);
          run_crc = zfe_pkg::CRC32_INIT;
          n_end++;
        end
        zfe_pkg::CMD_HEX: begin
          h = hdr_seed;
          put_raw(zfe_pkg::PAD_BYTE);
          put_raw(zfe_pkg::ESC_BYTE);
          put_raw(zfe_pkg::HEX_TAG);
          for (i = 0; i < 5; i++) begin
            h = crc16_step(h, field[i]);
            put_hex(field[i]);
          end
          put_hex(h[15:8]);
          put_hex(h[7:0]);
          put_raw(zfe_pkg::CR_BYTE);
          put_raw(zfe_pkg::LF_BYTE);
          n_hex++;
        end
        default: begin
          // binary header keeps its own CRC and leaves the subpacket CRC alone
          c = zfe_pkg::CRC32_INIT;
          put_raw(zfe_pkg::PAD_BYTE);
          put_raw(zfe_pkg::ESC_BYTE);
          put_raw(zfe_pkg::BIN_TAG);
          for (i = 0; i < 5; i++) begin
            c = crc32_step(c, field[i]);
            put_esc(field[i]);
          end
          c = ~c;
          for (i = 0; i < 4; i++) put_esc(c[31 - 8 * i -: 8]);
          n_bin++;
        end
      endcase
      // flag the final word of this input
      tail = line_q.pop_back();
      tail.last = 1'b1;
      line_q.push_back(tail);
    endfunction

    // Compare one emitted line word with the oldest prediction
    function void check_result(zfe_pkg::out_item_t got);
      zfe_pkg::out_item_t want;
      checked++;
      if (line_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected line word %h last %b", got.out_byte, got.last);
        return;
      end
      want = line_q.pop_front();
      if (got.out_byte !== want.out_byte || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: mismatch at word %0d: expected %h last %b, got %h last %b",
                   checked, want.out_byte, want.last, got.out_byte, got.last);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  zfe_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  zfe_pkg::out_item_t out_data;
  logic               cfg_wr_en = 1'b0;
  logic [15:0]        cfg_wr_data = 16'h0000;

  frame_scoreboard sb = new();

  bit calm;
  bit hold_req;
  bit hold_done;
  int hold_left;
  int stall_cycles;
  int seeds_used;

  zmodem_frame_encoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #10 clk = ~clk;

  // Receiver: random back-pressure, one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (calm) begin
      out_ready = 1'b1;
    end else begin
      out_ready = ($urandom_range(99) >= 6);
    end
  end

  // Check every line word taken by the receiver
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("tb: stalled for %0d cycles, %0d words outstanding",
                 STALL_LIMIT, sb.pending());
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic zfe_pkg::in_item_t make_word(zfe_pkg::cmd_t c, logic [7:0] b,
                                                  logic [31:0] arg);
    zfe_pkg::in_item_t w;
    w.cmd        = c;
    w.in_byte    = b;
    w.header_arg = arg;
    return w;
  endfunction

  // Bias toward bytes that need escaping
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(3) == 0) begin
      if ($urandom_range(3) == 0) return zfe_pkg::PAD_BYTE;
      return 8'($urandom_range(31));
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [31:0] pick_arg();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
      default: return $urandom();
    endcase
  endfunction

  // Offer one word, hold it until taken, then record it
  task automatic send_word(input zfe_pkg::in_item_t w);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 6) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data  = w;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(w);
  endtask

  // Drop valid and let every predicted word come out
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_seed(input logic [15:0] v);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_seed(v);
    seeds_used++;
  endtask

  // Mostly well-formed subpackets and headers, some stray words
  task automatic run_random(input int count);
    int sent;
    int len;
    int r;
    int k;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(99);
      if (r < 35) begin
        send_word(make_word(($urandom_range(1) != 0) ? zfe_pkg::CMD_HEX : zfe_pkg::CMD_BIN,
                            pick_byte(), pick_arg()));
        sent++;
      end else if (r < 45) begin
        send_word(make_word(zfe_pkg::cmd_t'($urandom_range(3)), 8'($urandom_range(255)),
                            $urandom()));
        sent++;
      end else begin
        len = $urandom_range(10);
        for (k = 0; k < len; k++) begin
          send_word(make_word(zfe_pkg::CMD_DATA, pick_byte(), $urandom()));
        end
        send_word(make_word(zfe_pkg::CMD_END, pick_byte(), $urandom()));
        sent += len + 1;
      end
    end
  endtask

  initial begin
    zfe_pkg::in_item_t dir_q[$];
    logic [15:0]       seeds [4];
    int                p;

    // hold reset low, then release it
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // escape boundaries, then end the subpacket over them
    dir_q.push_back(make_word(zfe_pkg::CMD_DATA, 8'h00, 32'h0000_0000));
    dir_q.push_back(make_word(zfe_pkg::CMD_DATA, 8'h1F, 32'hFFFF_FFFF));
    dir_q.push_back(make_word(zfe_pkg::CMD_DATA, 8'h20, 32'h0000_0000));
    dir_q.push_back(make_word(zfe_pkg::CMD_DATA, 8'h29, 32'h0000_0000));
    dir_q.push_back(make_word(zfe_pkg::CMD_DATA, 8'h2A, 32'h0000_0000));
    dir_q.push_back(make_word(zfe_pkg::CMD_DATA, 8'h2B, 32'h0000_0000));
    dir_q.push_back(make_word(zfe_pkg::CMD_DATA, 8'h18, 32'h0000_0000));
    dir_q.push_back(make_word(zfe_pkg::CMD_DATA, 8'hFF, 32'h0000_0000));
    dir_q.push_back(make_word(zfe_pkg::CMD_END, 8'h68, 32'h0000_0000));
    // empty subpackets with extreme flags
    dir_q.push_back(make_word(zfe_pkg::CMD_END, 8'h00, 32'hFFFF_FFFF));
    dir_q.push_back(make_word(zfe_pkg::CMD_END, 8'hFF, 32'h0000_0000));
    // headers at the extremes and with escapable bytes
    dir_q.push_back(make_word(zfe_pkg::CMD_HEX, 8'h00, 32'h0000_0000));
    dir_q.push_back(make_word(zfe_pkg::CMD_HEX, 8'hFF, 32'hFFFF_FFFF));
    dir_q.push_back(make_word(zfe_pkg::CMD_HEX, 8'h0A, 32'h1234_ABCD));
    dir_q.push_back(make_word(zfe_pkg::CMD_BIN, 8'h00, 32'h0000_0000));
    dir_q.push_back(make_word(zfe_pkg::CMD_BIN, 8'hFF, 32'hFFFF_FFFF));
    dir_q.push_back(make_word(zfe_pkg::CMD_BIN, 8'h2A, 32'h001F_2A18));
    // headers inside a subpacket must not disturb its CRC
    dir_q.push_back(make_word(zfe_pkg::CMD_DATA, 8'h41, 32'h0000_0000));
    dir_q.push_back(make_word(zfe_pkg::CMD_BIN, 8'h01, 32'h8000_0001));
    dir_q.push_back(make_word(zfe_pkg::CMD_HEX, 8'h02, 32'h7FFF_FFFE));
    dir_q.push_back(make_word(zfe_pkg::CMD_DATA, 8'h0D, 32'h0000_0000));
    dir_q.push_back(make_word(zfe_pkg::CMD_END, 8'h6B, 32'h0000_0000));
    foreach (dir_q[i]) send_word(dir_q[i]);
    drain();

    // random phases, one header seed each
    seeds[0] = 16'hFFFF;
    seeds[1] = 16'h0000;
    seeds[2] = 16'($urandom());
    seeds[3] = 16'($urandom());
    for (p = 0; p < 4; p++) begin
      write_seed(seeds[p]);
      calm     = (p == 1);
      hold_req = (p == 2);
      run_random(PHASE_WORDS);
      drain();
    end
    calm = 1'b0;

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("tb: %0d data, %0d end, %0d hex header, %0d binary header words in",
             sb.n_data, sb.n_end, sb.n_hex, sb.n_bin);
    $display("tb: %0d line words checked over %0d seed settings, %0d mismatches",
             sb.checked, seeds_used + 1, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/zfe_pkg.sv
sv/zmodem_frame_encoder_top.sv
tb/tb_top.sv
